// ===== design/c2m_pkg.sv =====
// Shared types and constants for the two-wire debug bus master.
package c2m_pkg;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	// Command codes carried by an input item.
	localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_ADDR  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ_ADDR   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE_DATA  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_DATA   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RESET       = 3'd5;

	// Configuration register indexes and reset values.
	localparam logic [0:0]        REG_WAIT_LIMIT   = 1'b0;
	localparam logic [BYTE_W-1:0] WAIT_LIMIT_RESET = 8'd100;

	typedef enum logic [2:0] {
		KIND_IDLE = 3'd0,
		KIND_WA   = 3'd1,
		KIND_RA   = 3'd2,
		KIND_WD   = 3'd3,
		KIND_RD   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_INS     = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_DATA    = 3'd3,
		PH_WAIT    = 3'd4,
		PH_STOP    = 3'd5,
		PH_STOP_TO = 3'd6
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BUSY    = 2'd0,
		ST_OK      = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] data_byte;
		logic              c2d_sample;
	} cmd_item_t;

	typedef struct packed {
		logic              clock_pulse;
		logic              data_drive;
		logic              data_level;
		logic              reset_pulse;
		status_t           status;
		logic [BYTE_W-1:0] read_data;
	} result_t;

endpackage

// ===== design/c2m_cmd_if.sv =====
// Input channel: command and tick items with valid/ready handshake.
interface c2m_cmd_if;
	import c2m_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] data_byte;
	logic              c2d_sample;

	modport source (output valid, output command, output data_byte, output c2d_sample,
		input ready);
	modport sink (input valid, input command, input data_byte, input c2d_sample,
		output ready);
endinterface

// ===== design/c2m_res_if.sv =====
// Output channel: one result item per input item, valid/ready handshake.
interface c2m_res_if;
	import c2m_pkg::*;

	logic                valid;
	logic                ready;
	logic                clock_pulse;
	logic                data_drive;
	logic                data_level;
	logic                reset_pulse;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   read_data;

	modport source (output valid, output clock_pulse, output data_drive, output data_level,
		output reset_pulse, output status, output read_data, input ready);
	modport sink (input valid, input clock_pulse, input data_drive, input data_level,
		input reset_pulse, input status, input read_data, output ready);
endinterface

// ===== design/c2m_apb_regs.sv =====
// APB configuration register file holding the WAIT poll limit.
module c2m_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [c2m_pkg::PADDR_W-1:0]  paddr,
	input  logic [c2m_pkg::PDATA_W-1:0]  pwdata,
	output logic [c2m_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [c2m_pkg::BYTE_W-1:0]   wait_limit
);
	import c2m_pkg::*;

	logic [BYTE_W-1:0] wait_limit_q;
	logic              sel_wait_limit;

	// Registers are word aligned; the low address bits are ignored.
	assign sel_wait_limit = (paddr[PADDR_W-1] == REG_WAIT_LIMIT);
	assign pready         = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_limit_q <= WAIT_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && sel_wait_limit) begin
			wait_limit_q <= pwdata[BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_wait_limit) begin
			prdata = {{(PDATA_W-BYTE_W){1'b0}}, wait_limit_q};
		end
	end

	assign wait_limit = wait_limit_q;
endmodule

// ===== design/c2m_frame_engine.sv =====
// Frame sequencer: holds frame state and computes one result per item.
module c2m_frame_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  c2m_pkg::cmd_item_t          item,
	input  logic [c2m_pkg::BYTE_W-1:0]  wait_limit,
	output c2m_pkg::result_t            result
);
	import c2m_pkg::*;

	typedef struct packed {
		kind_t             kind;
		phase_t            phase;
		logic [3:0]        bit_pos;
		logic [BYTE_W-1:0] shift_byte;
		logic [BYTE_W-1:0] wait_count;
	} frame_state_t;

	localparam frame_state_t IDLE_STATE = '{
		kind: KIND_IDLE, phase: PH_START, bit_pos: 4'd0, shift_byte: '0, wait_count: '0};

	frame_state_t      st_q;
	frame_state_t      st_next;
	logic [BYTE_W-1:0] lim;
	logic [BYTE_W-1:0] wc_inc;
	logic [3:0]        bp_inc;
	logic [1:0]        ins_code;
	logic              is_read;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE_STATE;
		end else if (step) begin
			st_q <= st_next;
		end
	end

	always_comb begin
		st_next = st_q;
		result  = '{clock_pulse: 1'b0, data_drive: 1'b0, data_level: 1'b0,
			reset_pulse: 1'b0, status: ST_BUSY, read_data: '0};
		lim     = (wait_limit == '0) ? BYTE_W'(1) : wait_limit;
		wc_inc  = (st_q.wait_count == '1) ? st_q.wait_count : st_q.wait_count + BYTE_W'(1);
		bp_inc  = st_q.bit_pos + 4'd1;
		is_read = (st_q.kind == KIND_RA) || (st_q.kind == KIND_RD);
		unique case (st_q.kind)
			KIND_WA: ins_code = 2'b11;
			KIND_RA: ins_code = 2'b10;
			KIND_WD: ins_code = 2'b01;
			default: ins_code = 2'b00;
		endcase

		if (st_q.kind == KIND_IDLE) begin
			if (item.command == CMD_TICK || item.command > CMD_RESET) begin
				result.status = ST_IGNORED;
			end else if (item.command == CMD_RESET) begin
				result.reset_pulse = 1'b1;
				result.status      = ST_OK;
			end else begin
				st_next      = IDLE_STATE;
				st_next.kind = kind_t'(item.command);
				if (item.command == CMD_WRITE_ADDR || item.command == CMD_WRITE_DATA) begin
					st_next.shift_byte = item.data_byte;
				end
			end
		end else if (item.command != CMD_TICK) begin
			result.status = ST_IGNORED;
		end else begin
			result.clock_pulse = 1'b1;
			unique case (st_q.phase)
				PH_START: begin
					st_next.phase   = PH_INS;
					st_next.bit_pos = 4'd0;
				end
				PH_INS: begin
					result.data_drive = 1'b1;
					result.data_level = ins_code[st_q.bit_pos[0]];
					st_next.bit_pos   = bp_inc;
					if (bp_inc >= 4'd2) begin
						st_next.bit_pos = 4'd0;
						st_next.phase   = (st_q.kind == KIND_WA || st_q.kind == KIND_RA) ?
							PH_DATA : PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					result.data_drive = 1'b1;
					st_next.bit_pos   = bp_inc;
					if (bp_inc >= 4'd2) begin
						st_next.bit_pos = 4'd0;
						st_next.phase   = (st_q.kind == KIND_WD) ? PH_DATA : PH_WAIT;
					end
				end
				PH_DATA: begin
					if (is_read) begin
						if (item.c2d_sample) begin
							st_next.shift_byte[st_q.bit_pos[2:0]] = 1'b1;
						end
					end else begin
						result.data_drive = 1'b1;
						result.data_level = st_q.shift_byte[st_q.bit_pos[2:0]];
					end
					st_next.bit_pos = bp_inc;
					if (bp_inc >= 4'd8) begin
						st_next.bit_pos = 4'd0;
						st_next.phase   = (st_q.kind == KIND_WD) ? PH_WAIT : PH_STOP;
					end
				end
				PH_WAIT: begin
					st_next.wait_count = wc_inc;
					if (item.c2d_sample) begin
						st_next.phase   = (st_q.kind == KIND_RD) ? PH_DATA : PH_STOP;
						st_next.bit_pos = 4'd0;
					end else if (wc_inc >= lim) begin
						if (st_q.kind == KIND_RD) begin
							// A timed-out read ends here, with no STOP pulse.
							result.status = ST_TIMEOUT;
							st_next       = IDLE_STATE;
						end else begin
							st_next.phase = PH_STOP_TO;
						end
					end
				end
				PH_STOP_TO: begin
					result.status = ST_TIMEOUT;
					st_next       = IDLE_STATE;
				end
				default: begin
					result.status = ST_OK;
					if (is_read) begin
						result.read_data = st_q.shift_byte;
					end
					st_next = IDLE_STATE;
				end
			endcase
		end
	end
endmodule

// ===== design/two_wire_debug_bus_master.sv =====
// Top level of the two-wire debug bus master: channels, registers and pipeline.
//
//  Channel | Dir | Handshake        | Payload
//  --------+-----+------------------+-------------------------------------------------
//  cmd     | in  | valid / ready    | command, data_byte, c2d_sample
//  res     | out | valid / ready    | clock_pulse, data_drive, data_level,
//          |     |                  | reset_pulse, status, read_data
//  apb     | in  | psel / penable   | pwrite, paddr, pwdata -> prdata (pready tied high)
//
// Each accepted item yields exactly one result item: it is captured in the input
// register, then the frame engine computes the result and the next frame state in
// one pass and the result register captures it. The engine's state update on that
// same edge sets the rate: one item per clock cycle sustained while the sink is ready.
// Reset (arst_n, asynchronous, active low) empties both registers, returns the frame
// engine to idle and sets the WAIT poll limit to 100. When the sink stalls, the
// result register holds its item while the input register can still take one more.
module two_wire_debug_bus_master (
	input  logic                        clk,
	input  logic                        arst_n,
	c2m_cmd_if.sink                     cmd,
	c2m_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [c2m_pkg::PADDR_W-1:0] paddr,
	input  logic [c2m_pkg::PDATA_W-1:0] pwdata,
	output logic [c2m_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import c2m_pkg::*;

	logic              item_valid_s1;
	cmd_item_t         item_s1;
	logic              res_valid_s2;
	result_t           result_s2;
	result_t           engine_result;
	logic [BYTE_W-1:0] wait_limit;
	logic              advance_s2;
	logic              move_s1;

	// Configuration registers.
	c2m_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.wait_limit (wait_limit)
	);

	// The result register frees up when it is empty or its item is taken this cycle.
	// The item in the input register moves on exactly then, and only then does the
	// frame engine commit its next state, so state and results stay in step.
	assign advance_s2 = !res_valid_s2 || res.ready;
	assign move_s1    = item_valid_s1 && advance_s2;
	assign cmd.ready  = !item_valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			item_valid_s1 <= cmd.valid;
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= '{command: cmd.command, data_byte: cmd.data_byte,
				c2d_sample: cmd.c2d_sample};
		end
	end

	c2m_frame_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (move_s1),
		.item       (item_s1),
		.wait_limit (wait_limit),
		.result     (engine_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			res_valid_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			result_s2 <= engine_result;
		end
	end

	assign res.valid       = res_valid_s2;
	assign res.clock_pulse = result_s2.clock_pulse;
	assign res.data_drive  = result_s2.data_drive;
	assign res.data_level  = result_s2.data_level;
	assign res.reset_pulse = result_s2.reset_pulse;
	assign res.status      = result_s2.status;
	assign res.read_data   = result_s2.read_data;
endmodule
